/* design/assert_macros.svh */
// Assertion macros used by the port-level checker of the rate monitor.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

/* design/mwrm_pkg.sv */
// Shared types and constants of the multi-window write rate monitor.
// Used by the window unit, the top level and the checker; depends on nothing.
package mwrm_pkg;

  localparam int DATA_W                = 64;
  localparam int LEVEL_SLOTS           = 3;
  localparam int WINDOW_LEVELS_DEFAULT = 3;
  localparam int CFG_INDEX_W           = 3;
  localparam int IN_TDATA_W            = 2 * DATA_W;
  localparam int OUT_FIELDS_W          = DATA_W + 5;
  localparam int OUT_TDATA_W           = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W             = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef logic [1:0] level_t;
  localparam level_t NO_LEVEL = 2'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_LEN_0,
    REG_WINDOW_LEN_1,
    REG_WINDOW_LEN_2,
    REG_BYTE_CAP_0,
    REG_BYTE_CAP_1,
    REG_BYTE_CAP_2
  } cfg_reg_t;

  localparam logic [CFG_INDEX_W-1:0] LEN_REG_BASE = REG_WINDOW_LEN_0;
  localparam logic [CFG_INDEX_W-1:0] CAP_REG_BASE = REG_BYTE_CAP_0;

  // Per-window result handed back to the top level.
  typedef struct packed {
    logic clipped;
    logic over_cap;
  } win_status_t;

  function automatic logic [DATA_W-1:0] len_reset(input int lvl);
    logic [DATA_W-1:0] v;
    case (lvl)
      0:       v = 64'd100;
      1:       v = 64'd1000;
      default: v = 64'd10000;
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] cap_reset(input int lvl);
    logic [DATA_W-1:0] v;
    case (lvl)
      0:       v = 64'd1048576;
      1:       v = 64'd8388608;
      default: v = 64'd67108864;
    endcase
    return v;
  endfunction

endpackage

/* design/mwrm_window.sv */
// One fixed window level: start tick, byte sum and valid mark, with its
// expiry test, saturating add and cap compare. Depends on mwrm_pkg.
module mwrm_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mwrm_pkg::DATA_W-1:0]   tick,
  input  logic [mwrm_pkg::DATA_W-1:0]   bytes,
  input  logic                          update,
  input  logic [mwrm_pkg::DATA_W-1:0]   len,
  input  logic [mwrm_pkg::DATA_W-1:0]   cap,
  output mwrm_pkg::win_status_t         status
);

  logic                          valid;
  logic [mwrm_pkg::DATA_W-1:0]   start;
  logic [mwrm_pkg::DATA_W-1:0]   sum;

  logic [mwrm_pkg::DATA_W-1:0]   elapsed;
  logic                          expired;
  logic [mwrm_pkg::DATA_W:0]     add_wide;
  logic [mwrm_pkg::DATA_W-1:0]   sum_next;

  always_comb begin
    elapsed  = tick - start;
    expired  = !valid || (elapsed >= len);
    add_wide = {1'b0, sum} + {1'b0, bytes};
    if (expired) begin
      sum_next = bytes;
    end else if (add_wide[mwrm_pkg::DATA_W]) begin
      sum_next = mwrm_pkg::ALL_ONES;
    end else begin
      sum_next = add_wide[mwrm_pkg::DATA_W-1:0];
    end
    status.clipped  = !expired && add_wide[mwrm_pkg::DATA_W];
    status.over_cap = sum_next > cap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      start <= '0;
      sum   <= '0;
    end else if (update) begin
      valid <= 1'b1;
      sum   <= sum_next;
      if (expired) begin
        start <= tick;
      end
    end
  end

endmodule

/* design/multi_window_write_rate_monitor.sv */
// Multi-window write rate monitor: one result beat per write-event beat.
// An accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls; each register holds
// one beat, so one more beat is taken while a result waits for m_axis_tready.
// Reset (rst, synchronous): clears windows, totals, tick tracking and the
// latched action, and loads the window lengths and byte caps with their defaults.
module multi_window_write_rate_monitor #(
  parameter int WINDOW_LEVELS = mwrm_pkg::WINDOW_LEVELS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [mwrm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mwrm_pkg::DATA_W-1:0]         cfg_data,
  // Write events.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] event_tick, [127:64] write_bytes
  input  logic [mwrm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Results.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] lifetime_total, [64] overflow_seen, [65] time_went_back,
  // [67:66] breached_level, [68] action_fired, [71:69] zero
  output logic [mwrm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int W = mwrm_pkg::DATA_W;

  // Configuration registers, one length and one cap per window level.
  logic [W-1:0] cfg_len [WINDOW_LEVELS];
  logic [W-1:0] cfg_cap [WINDOW_LEVELS];

  // Input register.
  logic         in_valid;
  logic [W-1:0] in_tick;
  logic [W-1:0] in_bytes;

  // Result register.
  logic                              out_valid;
  logic [mwrm_pkg::OUT_TDATA_W-1:0]  out_data;

  // Monitor state outside the windows.
  logic [W-1:0] lifetime_bytes;
  logic [W-1:0] last_tick;
  logic         clock_valid;
  logic         action_latched;

  // Per-beat decisions.
  logic                         commit;
  logic                         has_bytes;
  logic                         went_back;
  logic                         win_update;
  logic [W:0]                   life_wide;
  logic [W-1:0]                 lifetime_next;
  logic                         life_clip;
  logic                         win_clip;
  logic                         ovf;
  mwrm_pkg::level_t             breach;
  logic                         fired;
  mwrm_pkg::win_status_t        win_status [WINDOW_LEVELS];

  // The result stage moves when a beat sits in the input register and the
  // result register is empty or being drained this cycle.
  assign commit        = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || commit;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Configuration: each level picks up its own length and cap index.
  for (genvar g = 0; g < WINDOW_LEVELS; g++) begin : g_cfg
    always_ff @(posedge clk) begin
      if (rst) begin
        cfg_len[g] <= mwrm_pkg::len_reset(g);
        cfg_cap[g] <= mwrm_pkg::cap_reset(g);
      end else if (cfg_we) begin
        if (cfg_index == mwrm_pkg::LEN_REG_BASE + mwrm_pkg::CFG_INDEX_W'(g)) begin
          cfg_len[g] <= cfg_data;
        end
        if (cfg_index == mwrm_pkg::CAP_REG_BASE + mwrm_pkg::CFG_INDEX_W'(g)) begin
          cfg_cap[g] <= cfg_data;
        end
      end
    end
  end

  // Input register: take a beat whenever the slot is free or moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_tick  <= s_axis_tdata[W-1:0];
      in_bytes <= s_axis_tdata[2*W-1:W];
    end
  end

  // Zero bytes is a query: report the total and touch nothing. A tick below
  // the last tick that updated the windows still counts toward the total but skips them.
  assign has_bytes  = in_bytes != '0;
  assign went_back  = clock_valid && (in_tick < last_tick);
  assign win_update = commit && has_bytes && !went_back;

  for (genvar g = 0; g < WINDOW_LEVELS; g++) begin : g_win
    mwrm_window u_window (
      .clk    (clk),
      .rst    (rst),
      .tick   (in_tick),
      .bytes  (in_bytes),
      .update (win_update),
      .len    (cfg_len[g]),
      .cap    (cfg_cap[g]),
      .status (win_status[g])
    );
  end

  always_comb begin
    life_wide     = {1'b0, lifetime_bytes} + {1'b0, in_bytes};
    life_clip     = life_wide[W];
    lifetime_next = life_clip ? mwrm_pkg::ALL_ONES : life_wide[W-1:0];

    // Lowest level over its cap wins; scan from the top down.
    win_clip = 1'b0;
    breach   = mwrm_pkg::NO_LEVEL;
    for (int i = WINDOW_LEVELS - 1; i >= 0; i--) begin
      if (win_status[i].over_cap) begin
        breach = mwrm_pkg::level_t'(i);
      end
      win_clip = win_clip | win_status[i].clipped;
    end
    if (!has_bytes || went_back) begin
      win_clip = 1'b0;
      breach   = mwrm_pkg::NO_LEVEL;
    end

    ovf   = has_bytes && (life_clip || win_clip);
    fired = has_bytes && !action_latched &&
            (ovf || went_back || (breach != mwrm_pkg::NO_LEVEL));
  end

  // Monitor state advances only with a committed beat that carries bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime_bytes <= '0;
      last_tick      <= '0;
      clock_valid    <= 1'b0;
      action_latched <= 1'b0;
    end else if (commit && has_bytes) begin
      lifetime_bytes <= lifetime_next;
      if (!went_back) begin
        last_tick   <= in_tick;
        clock_valid <= 1'b1;
      end
      if (fired) begin
        action_latched <= 1'b1;
      end
    end
  end

  // Result register: hold until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= {{mwrm_pkg::OUT_PAD_W{1'b0}},
                   fired,
                   breach,
                   has_bytes && went_back,
                   ovf,
                   has_bytes ? lifetime_next : lifetime_bytes};
    end
  end

endmodule

/* design/mwrm_checker.sv */
// Port-level checker for the rate monitor, bound to the top level.
// Depends on mwrm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mwrm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [mwrm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int W = mwrm_pkg::DATA_W;

  logic              out_beat;
  logic              went_back;
  mwrm_pkg::level_t  level;
  logic              action;
  logic              fired_seen;

  assign out_beat  = m_axis_tvalid && m_axis_tready;
  assign went_back = m_axis_tdata[W+1];
  assign level     = m_axis_tdata[W+3:W+2];
  assign action    = m_axis_tdata[W+4];

  // Remember that an action has already gone out.
  always_ff @(posedge clk) begin
    if (rst) begin
      fired_seen <= 1'b0;
    end else if (out_beat && action) begin
      fired_seen <= 1'b1;
    end
  end

  `ASSERT_NEXT(a_hold_result, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMPL(a_back_no_breach, clk, rst, m_axis_tvalid && went_back, level == mwrm_pkg::NO_LEVEL)
  `ASSERT_IMPL(a_action_once, clk, rst, out_beat && fired_seen, !action)
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid)

endmodule

bind multi_window_write_rate_monitor mwrm_checker u_mwrm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/mwrm_checker.sv */
// Checker for the multi-window write rate monitor: watches the config port and both
// stream channels, predicts each result beat and compares it field by field.
// Depends on mwrm_pkg for widths, register indexes and the level type.
`timescale 1ns / 1ps

module mwrm_tb_checker
  import mwrm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // [63:0] event_tick, [127:64] write_bytes
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [63:0] lifetime_total, [64] overflow_seen, [65] time_went_back,
  // [67:66] breached_level, [68] action_fired, [71:69] zero
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     mismatch_count,
  output int                     pending_results,
  output int                     results_checked,
  output int                     breach_count,
  output int                     overflow_count,
  output int                     regress_count
);

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic                 action_fired;
    level_t               breached_level;
    logic                 time_went_back;
    logic                 overflow_seen;
    logic [DATA_W-1:0]    lifetime_total;
  } rate_result_t;

  localparam logic [DATA_W-1:0] LEN_DEFAULT [LEVEL_SLOTS] = '{64'd100, 64'd1000, 64'd10000};
  localparam logic [DATA_W-1:0] CAP_DEFAULT [LEVEL_SLOTS] =
    '{64'd1048576, 64'd8388608, 64'd67108864};

  logic [DATA_W-1:0] win_len   [LEVEL_SLOTS];
  logic [DATA_W-1:0] win_cap   [LEVEL_SLOTS];
  logic [DATA_W-1:0] total_bytes;
  logic [DATA_W-1:0] win_bytes [LEVEL_SLOTS];
  logic [DATA_W-1:0] win_start [LEVEL_SLOTS];
  logic              win_open  [LEVEL_SLOTS];
  logic [DATA_W-1:0] newest_tick;
  logic              tick_seen;
  logic              regress_flag;
  logic              action_done;

  rate_result_t expected_results [$];
  int fail_tally;
  int checked_tally;
  int breach_tally;
  int overflow_tally;
  int regress_tally;

  // Advance the monitor state by one write event and return its result beat.
  function automatic rate_result_t apply_write_event(input logic [DATA_W-1:0] tick,
                                                     input logic [DATA_W-1:0] nbytes);
    rate_result_t r;
    logic [DATA_W:0] wide;
    logic [DATA_W-1:0] s;
    r = '0;
    r.breached_level = NO_LEVEL;
    if (nbytes != '0) begin
      wide = {1'b0, total_bytes} + {1'b0, nbytes};
      r.overflow_seen = wide[DATA_W];
      total_bytes = wide[DATA_W] ? ALL_ONES : wide[DATA_W-1:0];
      if (tick_seen && tick < newest_tick) begin
        regress_flag = 1'b1;
        r.time_went_back = 1'b1;
      end else begin
        newest_tick = tick;
        tick_seen = 1'b1;
        for (int lvl = 0; lvl < LEVEL_SLOTS; lvl++) begin
          s = nbytes;
          // An unset or expired window restarts at this tick with this event alone.
          if (!win_open[lvl] || (tick - win_start[lvl]) >= win_len[lvl]) begin
            win_open[lvl] = 1'b1;
            win_start[lvl] = tick;
          end else begin
            wide = {1'b0, win_bytes[lvl]} + {1'b0, nbytes};
            if (wide[DATA_W]) begin
              s = ALL_ONES;
              r.overflow_seen = 1'b1;
            end else begin
              s = wide[DATA_W-1:0];
            end
          end
          win_bytes[lvl] = s;
          if (r.breached_level == NO_LEVEL && s > win_cap[lvl])
            r.breached_level = level_t'(lvl);
        end
      end
      if (!action_done && (r.overflow_seen || r.time_went_back || r.breached_level != NO_LEVEL)) begin
        action_done = 1'b1;
        r.action_fired = 1'b1;
      end
    end
    r.lifetime_total = total_bytes;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    fail_tally++;
    if (fail_tally <= 10)
      $display("mismatch %0d at %0t: %s expected %h, got %h", fail_tally, $realtime, what,
               want, got);
  endtask

  task automatic compare_result(input rate_result_t want, input rate_result_t got);
    if (got.lifetime_total !== want.lifetime_total)
      note_mismatch("lifetime_total", want.lifetime_total, got.lifetime_total);
    if (got.overflow_seen !== want.overflow_seen)
      note_mismatch("overflow_seen", DATA_W'(want.overflow_seen), DATA_W'(got.overflow_seen));
    if (got.time_went_back !== want.time_went_back)
      note_mismatch("time_went_back", DATA_W'(want.time_went_back),
                    DATA_W'(got.time_went_back));
    if (got.breached_level !== want.breached_level)
      note_mismatch("breached_level", DATA_W'(want.breached_level),
                    DATA_W'(got.breached_level));
    if (got.action_fired !== want.action_fired)
      note_mismatch("action_fired", DATA_W'(want.action_fired), DATA_W'(got.action_fired));
    if (got.pad !== want.pad)
      note_mismatch("tdata padding", DATA_W'(want.pad), DATA_W'(got.pad));
  endtask

  always @(posedge clk) begin
    rate_result_t got;
    rate_result_t want;
    if (rst) begin
      for (int lvl = 0; lvl < LEVEL_SLOTS; lvl++) begin
        win_len[lvl] = LEN_DEFAULT[lvl];
        win_cap[lvl] = CAP_DEFAULT[lvl];
        win_bytes[lvl] = '0;
        win_start[lvl] = '0;
        win_open[lvl] = 1'b0;
      end
      total_bytes = '0;
      newest_tick = '0;
      tick_seen = 1'b0;
      regress_flag = 1'b0;
      action_done = 1'b0;
      expected_results.delete();
      fail_tally = 0;
      checked_tally = 0;
      breach_tally = 0;
      overflow_tally = 0;
      regress_tally = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < CAP_REG_BASE)
          win_len[cfg_index - LEN_REG_BASE] = cfg_data;
        else if (cfg_index <= REG_BYTE_CAP_2)
          win_cap[cfg_index - CAP_REG_BASE] = cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = rate_result_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          note_mismatch("result beat with nothing expected", '0, got.lifetime_total);
        end else begin
          want = expected_results.pop_front();
          compare_result(want, got);
          checked_tally++;
          if (want.breached_level != NO_LEVEL) breach_tally++;
          if (want.overflow_seen) overflow_tally++;
          if (want.time_went_back) regress_tally++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_write_event(s_axis_tdata[DATA_W-1:0],
                                                     s_axis_tdata[2*DATA_W-1:DATA_W]));
    end
    mismatch_count  <= fail_tally;
    pending_results <= expected_results.size();
    results_checked <= checked_tally;
    breach_count    <= breach_tally;
    overflow_count  <= overflow_tally;
    regress_count   <= regress_tally;
  end

endmodule

/* tb/tb_multi_window_write_rate_monitor.sv */
// Testbench top for the multi-window write rate monitor: clock, reset, config phases,
// write-event stimulus and the verdict. Prediction and checking live in mwrm_tb_checker.
// Depends on mwrm_pkg, mwrm_tb_checker and the monitor RTL.
`timescale 1ns / 1ps

module tb_multi_window_write_rate_monitor;
  import mwrm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int GAP_PERCENT = 34;
  // Indexes past the last register: writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DATA_W-1:0]      cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [63:0] event_tick, [127:64] write_bytes
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [63:0] lifetime_total, [64] overflow_seen, [65] time_went_back,
  // [67:66] breached_level, [68] action_fired, [71:69] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int breach_count;
  int overflow_count;
  int regress_count;

  // Stimulus bookkeeping: current settings and the newest forward tick sent.
  logic [DATA_W-1:0] lens [LEVEL_SLOTS];
  logic [DATA_W-1:0] caps [LEVEL_SLOTS];
  logic [DATA_W-1:0] tick_now;
  bit                no_gaps;
  int                events_sent;
  int                settings_used;
  int                cycle_count = 0;

  multi_window_write_rate_monitor uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mwrm_tb_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .breach_count    (breach_count),
    .overflow_count  (overflow_count),
    .regress_count   (regress_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result channel at random, except during the no-gap stretch.
  always @(posedge clk) begin
    if (no_gaps) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= GAP_PERCENT);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results);
      $display("FAIL multi_window_write_rate_monitor");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one write-event beat and hold it until the monitor takes it. Valid stays
  // high on return so back-to-back beats need no extra assignment.
  task automatic post_event(input logic [DATA_W-1:0] tick, input logic [DATA_W-1:0] nbytes);
    while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {nbytes, tick};
    do @(posedge clk); while (!s_axis_tready);
    if (nbytes != '0 && tick >= tick_now) tick_now = tick;
    events_sent++;
  endtask

  // Drop valid and hold until every result beat is back, then let the pipe settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [DATA_W-1:0] l0, input logic [DATA_W-1:0] l1,
                               input logic [DATA_W-1:0] l2, input logic [DATA_W-1:0] c0,
                               input logic [DATA_W-1:0] c1, input logic [DATA_W-1:0] c2);
    wait_drained();
    lens[0] = l0;
    lens[1] = l1;
    lens[2] = l2;
    caps[0] = c0;
    caps[1] = c1;
    caps[2] = c2;
    put_reg(REG_WINDOW_LEN_0, l0);
    put_reg(REG_WINDOW_LEN_1, l1);
    put_reg(REG_WINDOW_LEN_2, l2);
    put_reg(REG_BYTE_CAP_0, c0);
    put_reg(REG_BYTE_CAP_1, c1);
    put_reg(REG_BYTE_CAP_2, c2);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One random event. Most are forward or equal ticks with byte counts scaled to a
  // cap so that windows fill, expire and breach; the rest are queries with
  // arbitrary ticks and backward ticks. Wild byte counts saturate the lifetime
  // total for good, so they are held back for the last phase.
  task automatic post_random_event(input bit wild_bytes);
    int unsigned pick;
    int unsigned lvl;
    int unsigned span;
    int unsigned back_by;
    logic [DATA_W-1:0] tick;
    logic [DATA_W-1:0] nbytes;
    logic [DATA_W-1:0] scale;
    pick = $urandom_range(99);
    lvl  = $urandom_range(LEVEL_SLOTS - 1);
    span = (lens[lvl] > 64'd4000) ? 4000 : int'(lens[lvl]) + 2;
    if (wild_bytes) begin
      nbytes = rand64() >> $urandom_range(63);
    end else begin
      scale = (caps[lvl] > 64'd67108864) ? 64'd67108864 : caps[lvl];
      nbytes = (scale >> $urandom_range(6)) + 64'($urandom_range(255));
    end
    if (pick < 8) begin
      tick = rand64();
      nbytes = '0;
    end else if (pick < 14 && tick_now != '0) begin
      back_by = $urandom_range(1000, 1);
      tick = (tick_now > 64'(back_by)) ? tick_now - 64'(back_by) : '0;
    end else if (pick < 30) begin
      tick = tick_now;
    end else begin
      tick = tick_now + 64'($urandom_range(span, 1));
    end
    post_event(tick, nbytes);
  endtask

  task automatic random_run(input int count, input bit wild_bytes);
    for (int n = 0; n < count; n++) post_random_event(wild_bytes);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_WINDOW_LEN_0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    no_gaps       = 1'b0;
    tick_now      = '0;
    events_sent   = 0;
    settings_used = 1;
    lens[0] = 64'd100;
    lens[1] = 64'd1000;
    lens[2] = 64'd10000;
    caps[0] = 64'd1048576;
    caps[1] = 64'd8388608;
    caps[2] = 64'd67108864;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk at the reset settings.
    post_event('0, '0);                        // query before any event
    post_event(ALL_ONES, '0);                  // query at the top tick leaves state alone
    post_event(64'd10, 64'd1);                 // first event opens all windows
    post_event(64'd10, 64'd5);                 // equal tick is not backwards
    post_event(64'd60, 64'd1000);
    post_event(64'd110, 64'd2000000);          // level 0 expires exactly, breaches, action fires
    post_event(64'd120, 64'd7000000);          // breach again, action stays quiet
    post_event(64'd250, 64'd500000);           // level 0 restarts, level 1 over its cap
    post_event(64'd2000, 64'd60000000);
    post_event(64'd5000, 64'd1000);            // only level 2 over its cap
    post_event(64'd4999, 64'd1);               // backward tick
    post_event(64'd3, '0);                     // query with a backward tick
    post_event(64'd5000, 64'd1);               // back at the last forward tick
    post_event(64'h0000_0000_5555_5555, 64'h0000_0000_00AA_AAAA);
    post_event(64'h0000_0000_5555_5555 + 64'd100000, 64'd1);   // every window expires
    post_event(64'hAAAA_AAAA_AAAA_AAAA, '0);
    post_event(64'h0000_0000_5555_5555 + 64'd100001, 64'd7);

    random_run(300, 1'b0);

    // Short windows, low caps; the first stretch runs with no gaps on either side.
    load_settings(64'd1, 64'd5, 64'd40, 64'd3000, 64'd20000, 64'd100000);
    put_reg(REG_UNMAPPED_LO, rand64());
    put_reg(REG_UNMAPPED_HI, '0);
    cfg_we  <= 1'b0;
    no_gaps = 1'b1;
    random_run(200, 1'b0);
    no_gaps = 1'b0;
    random_run(150, 1'b0);

    // Zero-length windows always hold only the current event; cap zero breaches at once.
    load_settings('0, '0, '0, '0, 64'd1, 64'd50000);
    random_run(250, 1'b0);

    load_settings(64'($urandom_range(5000, 1)), 64'($urandom_range(5000, 1)),
                  64'($urandom_range(5000, 1)), 64'($urandom_range(1 << 24, 1000)),
                  64'($urandom_range(1 << 24, 1000)), 64'($urandom_range(1 << 24, 1000)));
    random_run(350, 1'b0);

    // Windows never expire; push the lifetime total and the window sums into saturation.
    load_settings(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 64'h0000_0100_0000_0000, ALL_ONES);
    post_event(tick_now + 64'd1, ALL_ONES - 64'd1);   // lifetime total clips
    post_event(tick_now + 64'd1, 64'd1);
    post_event(tick_now + 64'd1, 64'd1);              // window sums clip too
    post_event(tick_now + 64'd1, ALL_ONES);
    random_run(400, 1'b1);
    post_event(ALL_ONES, 64'd5);                      // top tick
    post_event(ALL_ONES, 64'd5);
    post_event('0, 64'd5);                            // everything below is now backwards
    post_event(ALL_ONES - 64'd1, 64'd3);

    wait_drained();
    $display("Covered %0d write events over %0d register settings, %0d result beats checked.",
             events_sent, settings_used, results_checked);
    $display("Seen: %0d cap breaches, %0d clipped additions, %0d backward ticks.",
             breach_count, overflow_count, regress_count);
    if (mismatch_count == 0) begin
      $display("PASS multi_window_write_rate_monitor");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL multi_window_write_rate_monitor");
    end
    $finish;
  end

endmodule
